@@ rtl/sth_pkg.sv @@
`default_nettype none
package sth_pkg;

  localparam int POS_W  = 63;
  localparam int VEL_W  = 48;
  localparam int MOON_W = 46;
  localparam int STEP_W = 10;
  localparam int MAG_W  = 63;
  localparam int EX_W   = 31;
  localparam int SQ_W   = 63;
  localparam int RS_W   = 32;
  localparam int RM_W   = 48;
  localparam int Q1_W   = 42;
  localparam int DV_W   = 30;
  localparam int RQ_W   = 56;

  localparam logic [MOON_W-1:0] MOON_STEP = 46'd19660800000;
  localparam logic [RM_W-1:0]   RMIN      = 48'd2084400;
  localparam logic [SQ_W-1:0]   GMDT128   = 63'd6272346956800000000;

  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_TARGET_X = 3'd2;
  localparam logic [2:0] REG_TARGET_Y = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;

  typedef struct packed {
    logic [MOON_W-1:0]       moonx;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [STEP_W-1:0]       step;
    logic                    hit;
    logic [STEP_W-1:0]       hit_step;
  } slot_t;

  typedef struct packed {
    logic [EX_W-1:0] ex;
    logic [EX_W-1:0] ey;
    logic [5:0]      s;
    logic            negx;
    logic            negy;
    logic            zero;
  } geo_t;

endpackage
`default_nettype wire

@@ rtl/slingshot_trajectory_hit_test.sv @@
`default_nettype none
// Integrates one trial launch velocity per request for up to STEPS Euler steps under the
// moving moon's gravity, freezing a trial at its hit, and reports hit, hit step and the
// final position in meters. One step is a ring of 147 register stages (bit-per-stage
// square root and dividers dominate); a trial makes STEPS passes round it, and its result
// strobes on out_valid after the last pass, always in request order. Up to 147 trials are
// in flight, and a new trial can be taken whenever the ring slot at the head is free.
// busy is high in a cycle whose ring slot is occupied; start is taken when it is low.
// out_valid lasts one cycle and cannot be held off. Write the registers only when idle.
module slingshot_trajectory_hit_test #(
  parameter int STEPS = 100
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [5:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [15:0]         in_launch_vel_x,
  input  logic signed [15:0]         in_launch_vel_y,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [sth_pkg::STEP_W-1:0] out_hit_step,
  output logic signed [46:0]         out_final_x,
  output logic signed [46:0]         out_final_y
);
  import sth_pkg::*;

  localparam int SLOT_W = $bits(slot_t);
  localparam int GEO_W  = $bits(geo_t);

  function automatic logic [VEL_W-1:0] sat_vel(input logic [VEL_W:0] v);
    logic [VEL_W-1:0] res;
    res = v[VEL_W-1:0];
    if (v[VEL_W] != v[VEL_W-1]) begin
      res = v[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
    logic [POS_W-1:0] res;
    res = v[POS_W-1:0];
    if (v[POS_W] != v[POS_W-1]) begin
      res = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

  // configuration
  logic [40:0] start_x_r, start_y_r, target_x_r, target_y_r;
  logic [39:0] radius_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r  <= 41'd30000000;
      start_y_r  <= -41'sd20000000;
      target_x_r <= 41'd40000000;
      target_y_r <= 41'd30000000;
      radius_r   <= 40'd100000;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_START_X:  start_x_r  <= pwdata[40:0];
        REG_START_Y:  start_y_r  <= pwdata[40:0];
        REG_TARGET_X: target_x_r <= pwdata[40:0];
        REG_TARGET_Y: target_y_r <= pwdata[40:0];
        REG_RADIUS:   radius_r   <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_START_X:  prdata = 64'(start_x_r);
      REG_START_Y:  prdata = 64'(start_y_r);
      REG_TARGET_X: prdata = 64'(target_x_r);
      REG_TARGET_Y: prdata = 64'(target_y_r);
      REG_RADIUS:   prdata = 64'(radius_r);
      default:      prdata = '0;
    endcase
  end

  // ring head: recirculating slot or a fresh request
  slot_t ring_r;
  logic  ring_v_r;
  logic  accept;
  slot_t head;
  logic  head_v;

  assign busy   = ring_v_r;
  assign accept = start && !ring_v_r;
  assign head_v = ring_v_r || accept;

  always_comb begin
    head = ring_r;
    if (accept) begin
      head.moonx    = '0;
      head.vx       = {{(VEL_W-32){in_launch_vel_x[15]}}, in_launch_vel_x, 16'b0};
      head.vy       = {{(VEL_W-32){in_launch_vel_y[15]}}, in_launch_vel_y, 16'b0};
      head.px       = {{(POS_W-57){start_x_r[40]}}, start_x_r, 16'b0};
      head.py       = {{(POS_W-57){start_y_r[40]}}, start_y_r, 16'b0};
      head.step     = '0;
      head.hit      = 1'b0;
      head.hit_step = '0;
    end
  end

  // stage A: offset to moon and magnitudes
  logic [63:0] a_dx, a_dy;
  logic              a_v_r, a_negx_r, a_negy_r;
  slot_t             a_st_r;
  logic [MAG_W-1:0]  a_ax_r, a_ay_r;

  assign a_dx = {18'b0, head.moonx} - {head.px[POS_W-1], head.px};
  assign a_dy = 64'(0) - {head.py[POS_W-1], head.py};

  // stage B: shift that brings both magnitudes below 2^31
  logic [MAG_W-1:0] b_or;
  logic [6:0]       b_len;
  logic [5:0]       b_s;
  logic             b_v_r, b_negx_r, b_negy_r;
  slot_t            b_st_r;
  logic [MAG_W-1:0] b_ax_r, b_ay_r;
  logic [5:0]       b_s_r;

  assign b_or = a_ax_r | a_ay_r;
  always_comb begin
    b_len = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (b_or[i]) b_len = 7'(i + 1);
    end
    b_s = (b_len > 7'd31) ? 6'(b_len - 7'd31) : '0;
  end

  // stage C: scaled components
  logic [MAG_W-1:0] c_shx, c_shy;
  geo_t             c_geo;
  logic             c_v_r;
  slot_t            c_st_r;
  geo_t             c_geo_r;

  assign c_shx = b_ax_r >> b_s_r;
  assign c_shy = b_ay_r >> b_s_r;
  always_comb begin
    c_geo.ex   = c_shx[EX_W-1:0];
    c_geo.ey   = c_shy[EX_W-1:0];
    c_geo.s    = b_s_r;
    c_geo.negx = b_negx_r;
    c_geo.negy = b_negy_r;
    c_geo.zero = (c_shx[EX_W-1:0] == '0) && (c_shy[EX_W-1:0] == '0);
  end

  // stage D: squares, stage E: sum
  logic [2*EX_W-1:0] d_sqx, d_sqy;
  logic              d_v_r, e_v_r;
  slot_t             d_st_r, e_st_r;
  geo_t              d_geo_r, e_geo_r;
  logic [2*EX_W-1:0] d_sqx_r, d_sqy_r;
  logic [SQ_W-1:0]   e_sum_r;

  assign d_sqx = c_geo_r.ex * c_geo_r.ex;
  assign d_sqy = c_geo_r.ey * c_geo_r.ey;

  always_ff @(posedge clk) begin
    a_st_r   <= head;
    a_ax_r   <= a_dx[63] ? MAG_W'(64'(0) - a_dx) : a_dx[MAG_W-1:0];
    a_ay_r   <= a_dy[63] ? MAG_W'(64'(0) - a_dy) : a_dy[MAG_W-1:0];
    a_negx_r <= a_dx[63];
    a_negy_r <= a_dy[63];
    b_st_r   <= a_st_r;
    b_ax_r   <= a_ax_r;
    b_ay_r   <= a_ay_r;
    b_negx_r <= a_negx_r;
    b_negy_r <= a_negy_r;
    b_s_r    <= b_s;
    c_st_r   <= b_st_r;
    c_geo_r  <= c_geo;
    d_st_r   <= c_st_r;
    d_geo_r  <= c_geo_r;
    d_sqx_r  <= d_sqx;
    d_sqy_r  <= d_sqy;
    e_st_r   <= d_st_r;
    e_geo_r  <= d_geo_r;
    e_sum_r  <= SQ_W'(d_sqx_r) + SQ_W'(d_sqy_r);
  end

  // square root of the scaled distance
  logic                    sq_v;
  logic [RS_W-1:0]         sq_root;
  logic [SLOT_W+GEO_W-1:0] sq_tag;
  slot_t                   sq_st;
  geo_t                    sq_geo;

  sth_sqrt_pipe #(.TW(SLOT_W + GEO_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (e_v_r),
    .in_rad   (e_sum_r),
    .in_tag   ({e_st_r, e_geo_r}),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  assign {sq_st, sq_geo} = sq_tag;

  // stage F: true distance in meters, clamped
  logic [63:0]     f_wide;
  logic [RM_W-1:0] f_rm;
  logic            f_v_r;
  slot_t           f_st_r;
  geo_t            f_geo_r;
  logic [RS_W-1:0] f_rs_r;
  logic [RM_W-1:0] f_rm_r;

  assign f_wide = {32'b0, sq_root} << sq_geo.s;
  assign f_rm   = (f_wide[63:16] < RMIN) ? RMIN : f_wide[63:16];

  always_ff @(posedge clk) begin
    f_st_r  <= sq_st;
    f_geo_r <= sq_geo;
    f_rs_r  <= sq_root;
    f_rm_r  <= f_rm;
  end

  localparam int T1_W = SLOT_W + GEO_W + RS_W;

  logic            d1_v, d2_v;
  logic [Q1_W-1:0] d1_q;
  logic [RM_W-1:0] d1_den;
  logic [T1_W-1:0] d1_tag, d2_tag;
  logic [DV_W-1:0] d2_q;

  sth_div_pipe #(.NW(SQ_W), .DW(RM_W), .QW(Q1_W), .TW(T1_W)) u_div_gm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_v_r),
    .in_num   (GMDT128),
    .in_den   (f_rm_r),
    .in_tag   ({f_st_r, f_geo_r, f_rs_r}),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_den  (d1_den),
    .out_tag  (d1_tag)
  );

  sth_div_pipe #(.NW(Q1_W + 9), .DW(RM_W), .QW(DV_W), .TW(T1_W)) u_div_dv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d1_v),
    .in_num   ({d1_q, 9'b0}),
    .in_den   (d1_den),
    .in_tag   (d1_tag),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_den  (),
    .out_tag  (d2_tag)
  );

  // stage G: scale the velocity change by each component
  slot_t                g_st;
  geo_t                 g_geo;
  logic [RS_W-1:0]      g_rs;
  logic [DV_W+EX_W-1:0] g_mx, g_my;
  logic                 g_v_r;
  slot_t                g_st_r;
  geo_t                 g_geo_r;
  logic [RS_W-1:0]      g_rs_r;
  logic [DV_W+EX_W-1:0] g_mx_r, g_my_r;

  assign {g_st, g_geo, g_rs} = d2_tag;
  assign g_mx = d2_q * g_geo.ex;
  assign g_my = d2_q * g_geo.ey;

  always_ff @(posedge clk) begin
    g_st_r  <= g_st;
    g_geo_r <= g_geo;
    g_rs_r  <= g_rs;
    g_mx_r  <= g_mx;
    g_my_r  <= g_my;
  end

  logic              d3_v;
  logic [DV_W-1:0]   d3_qx, d3_qy;
  logic [SLOT_W+1:0] d3_tag;
  logic              d3y_tag;
  slot_t             d3_st;
  logic              d3_negx, d3_zero;

  sth_div_pipe #(.NW(DV_W + EX_W), .DW(RS_W), .QW(DV_W), .TW(SLOT_W + 2)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (g_v_r),
    .in_num   (g_mx_r),
    .in_den   (g_rs_r),
    .in_tag   ({g_st_r, g_geo_r.negx, g_geo_r.zero}),
    .out_valid(d3_v),
    .out_quo  (d3_qx),
    .out_den  (),
    .out_tag  (d3_tag)
  );

  sth_div_pipe #(.NW(DV_W + EX_W), .DW(RS_W), .QW(DV_W), .TW(1)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (g_v_r),
    .in_num   (g_my_r),
    .in_den   (g_rs_r),
    .in_tag   (g_geo_r.negy),
    .out_valid(),
    .out_quo  (d3_qy),
    .out_den  (),
    .out_tag  (d3y_tag)
  );

  assign {d3_st, d3_negx, d3_zero} = d3_tag;

  // stage H: velocity update
  logic [DV_W:0]    h_gx, h_gy;
  logic             h_v_r;
  slot_t            h_st_r;
  logic [VEL_W-1:0] h_vx_r, h_vy_r;

  always_comb begin
    h_gx = '0;
    h_gy = '0;
    if (!d3_zero) begin
      h_gx = d3_negx ? (DV_W+1)'(0) - {1'b0, d3_qx} : {1'b0, d3_qx};
      h_gy = d3y_tag ? (DV_W+1)'(0) - {1'b0, d3_qy} : {1'b0, d3_qy};
    end
  end

  // stage I: position update and moon advance
  logic [55:0] i_dpx, i_dpy;
  logic        i_v_r;
  slot_t       i_st_r, i_nw_r;
  slot_t       i_nw;

  assign i_dpx = {{(56-VEL_W){h_vx_r[VEL_W-1]}}, h_vx_r} * 56'd200;
  assign i_dpy = {{(56-VEL_W){h_vy_r[VEL_W-1]}}, h_vy_r} * 56'd200;
  always_comb begin
    i_nw       = h_st_r;
    i_nw.vx    = h_vx_r;
    i_nw.vy    = h_vy_r;
    i_nw.px    = sat_pos({h_st_r.px[POS_W-1], h_st_r.px} + {{8{i_dpx[55]}}, i_dpx});
    i_nw.py    = sat_pos({h_st_r.py[POS_W-1], h_st_r.py} + {{8{i_dpy[55]}}, i_dpy});
    i_nw.moonx = h_st_r.moonx + MOON_STEP;
  end

  always_ff @(posedge clk) begin
    h_st_r <= d3_st;
    h_vx_r <= sat_vel({d3_st.vx[VEL_W-1], d3_st.vx} + {{(VEL_W-DV_W){h_gx[DV_W]}}, h_gx});
    h_vy_r <= sat_vel({d3_st.vy[VEL_W-1], d3_st.vy} + {{(VEL_W-DV_W){h_gy[DV_W]}}, h_gy});
    i_st_r <= h_st_r;
    i_nw_r <= i_nw;
  end

  // stage J: offsets to target, range check against the radius
  logic [63:0]      j_ox, j_oy;
  logic [MAG_W-1:0] j_ax, j_ay;
  logic [RQ_W-1:0]  j_rq;
  logic             j_v_r, j_oor_r;
  slot_t            j_st_r, j_nw_r;
  logic [RQ_W-1:0]  j_ax_r, j_ay_r;

  assign j_ox = {i_nw_r.px[POS_W-1], i_nw_r.px} - {{7{target_x_r[40]}}, target_x_r, 16'b0};
  assign j_oy = {i_nw_r.py[POS_W-1], i_nw_r.py} - {{7{target_y_r[40]}}, target_y_r, 16'b0};
  assign j_ax = j_ox[63] ? MAG_W'(64'(0) - j_ox) : j_ox[MAG_W-1:0];
  assign j_ay = j_oy[63] ? MAG_W'(64'(0) - j_oy) : j_oy[MAG_W-1:0];
  assign j_rq = {radius_r, 16'b0};

  // stage K: partial products, stage L: full squares
  localparam int H_W = RQ_W / 2;

  logic              k_v_r, k_oor_r;
  slot_t             k_st_r, k_nw_r;
  logic [2*H_W-1:0]  k_x11_r, k_x10_r, k_x00_r, k_y11_r, k_y10_r, k_y00_r;
  logic [39:0]       k_r11_r, k_r10_r, k_r00_r;
  logic              l_v_r, l_oor_r;
  slot_t             l_st_r, l_nw_r;
  logic [2*RQ_W-1:0] l_sqx_r, l_sqy_r;
  logic [79:0]       l_rr_r;

  always_ff @(posedge clk) begin
    j_st_r  <= i_st_r;
    j_nw_r  <= i_nw_r;
    j_ax_r  <= j_ax[RQ_W-1:0];
    j_ay_r  <= j_ay[RQ_W-1:0];
    j_oor_r <= (j_ax > MAG_W'(j_rq)) || (j_ay > MAG_W'(j_rq));
    k_st_r  <= j_st_r;
    k_nw_r  <= j_nw_r;
    k_oor_r <= j_oor_r;
    k_x11_r <= j_ax_r[RQ_W-1:H_W] * j_ax_r[RQ_W-1:H_W];
    k_x10_r <= j_ax_r[RQ_W-1:H_W] * j_ax_r[H_W-1:0];
    k_x00_r <= j_ax_r[H_W-1:0] * j_ax_r[H_W-1:0];
    k_y11_r <= j_ay_r[RQ_W-1:H_W] * j_ay_r[RQ_W-1:H_W];
    k_y10_r <= j_ay_r[RQ_W-1:H_W] * j_ay_r[H_W-1:0];
    k_y00_r <= j_ay_r[H_W-1:0] * j_ay_r[H_W-1:0];
    k_r11_r <= radius_r[39:20] * radius_r[39:20];
    k_r10_r <= radius_r[39:20] * radius_r[19:0];
    k_r00_r <= radius_r[19:0] * radius_r[19:0];
    l_st_r  <= k_st_r;
    l_nw_r  <= k_nw_r;
    l_oor_r <= k_oor_r;
    l_sqx_r <= ((2*RQ_W)'(k_x11_r) << RQ_W) + ((2*RQ_W)'(k_x10_r) << (H_W + 1))
               + (2*RQ_W)'(k_x00_r);
    l_sqy_r <= ((2*RQ_W)'(k_y11_r) << RQ_W) + ((2*RQ_W)'(k_y10_r) << (H_W + 1))
               + (2*RQ_W)'(k_y00_r);
    l_rr_r  <= (80'(k_r11_r) << 40) + (80'(k_r10_r) << 21) + 80'(k_r00_r);
  end

  // stage M: hit decision, freeze after a hit, close the ring
  logic [2*RQ_W:0] m_sum;
  logic            m_hit;
  logic            m_last;
  slot_t           m_st;
  logic            out_valid_r;

  assign m_sum  = {1'b0, l_sqx_r} + {1'b0, l_sqy_r};
  assign m_hit  = !l_oor_r && (m_sum <= {1'b0, l_rr_r, 32'b0});
  assign m_last = (l_st_r.step == STEP_W'(STEPS - 1));

  always_comb begin
    m_st = l_st_r.hit ? l_st_r : l_nw_r;
    if (!l_st_r.hit && m_hit) begin
      m_st.hit      = 1'b1;
      m_st.hit_step = l_st_r.step;
    end
    m_st.step = l_st_r.step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    ring_r       <= m_st;
    out_hit      <= m_st.hit;
    out_hit_step <= m_st.hit_step;
    out_final_x  <= m_st.px[POS_W-1:16];
    out_final_y  <= m_st.py[POS_W-1:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      g_v_r       <= 1'b0;
      h_v_r       <= 1'b0;
      i_v_r       <= 1'b0;
      j_v_r       <= 1'b0;
      k_v_r       <= 1'b0;
      l_v_r       <= 1'b0;
      ring_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_v_r       <= head_v;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      d_v_r       <= c_v_r;
      e_v_r       <= d_v_r;
      f_v_r       <= sq_v;
      g_v_r       <= d2_v;
      h_v_r       <= d3_v;
      i_v_r       <= h_v_r;
      j_v_r       <= i_v_r;
      k_v_r       <= j_v_r;
      l_v_r       <= k_v_r;
      // drop the slot after its last pass
      ring_v_r    <= l_v_r && !m_last;
      out_valid_r <= l_v_r && m_last;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_step == '0)
    else $error("miss reported with nonzero step");
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> {1'b0, out_hit_step} < 11'(STEPS))
    else $error("hit step beyond run length");
  a_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(l_v_r))
    else $error("result without a slot at the ring tail");
  a_slot_once: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_v_r && out_valid))
    else $error("slot both recirculated and retired");
`endif

endmodule
`default_nettype wire

@@ rtl/sth_div_pipe.sv @@
`default_nettype none
module sth_div_pipe #(
  parameter int NW = 63,
  parameter int DW = 48,
  parameter int QW = 42,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [TW-1:0] out_tag
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r   [QW];
  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];
  logic [NW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [CW-1:0] trial;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = in_num;
        din = in_den;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        din = den_r[k-1];
        qin = quo_r[k-1];
      end
      trial = CW'(din) << (QW - 1 - k);
      rem_nxt[k] = rin;
      quo_nxt[k] = qin;
      if (CW'(rin) >= trial) begin
        rem_nxt[k] = NW'(CW'(rin) - trial);
        quo_nxt[k][QW-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      den_r[k] <= (k == 0) ? in_den : den_r[k-1];
      tag_r[k] <= (k == 0) ? in_tag : tag_r[k-1];
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_den   = den_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule
`default_nettype wire

@@ rtl/sth_sqrt_pipe.sv @@
`default_nettype none
module sth_sqrt_pipe #(
  parameter int TW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [sth_pkg::SQ_W-1:0] in_rad,
  input  logic [TW-1:0]            in_tag,
  output logic                     out_valid,
  output logic [sth_pkg::RS_W-1:0] out_root,
  output logic [TW-1:0]            out_tag
);
  import sth_pkg::*;

  localparam int NS = RS_W;

  logic            v_r   [NS];
  logic [SQ_W-1:0] x_r   [NS];
  logic [SQ_W-1:0] r_r   [NS];
  logic [TW-1:0]   tag_r [NS];
  logic [SQ_W-1:0] x_nxt [NS];
  logic [SQ_W-1:0] r_nxt [NS];

  // two radicand bits per stage
  always_comb begin
    logic [SQ_W-1:0] xin;
    logic [SQ_W-1:0] rin;
    logic [SQ_W-1:0] bitv;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        xin = in_rad;
        rin = '0;
      end else begin
        xin = x_r[k-1];
        rin = r_r[k-1];
      end
      bitv = SQ_W'(1) << (SQ_W - 1 - 2 * k);
      x_nxt[k] = xin;
      r_nxt[k] = rin >> 1;
      if (xin >= rin + bitv) begin
        x_nxt[k] = xin - (rin + bitv);
        r_nxt[k] = (rin >> 1) + bitv;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
      x_r[k]   <= x_nxt[k];
      r_r[k]   <= r_nxt[k];
      tag_r[k] <= (k == 0) ? in_tag : tag_r[k-1];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = r_r[NS-1][RS_W-1:0];
  assign out_tag   = tag_r[NS-1];

endmodule
`default_nettype wire

@@ tb/tb_slingshot_trajectory_hit_test.sv @@
`timescale 1ns / 100ps
module tb_slingshot_trajectory_hit_test;
  import sth_pkg::*;

  localparam int  NSTEPS     = 100;
  localparam int  RING       = 147;
  localparam int  CYCLE_CAP  = 2000000;
  localparam longint POS_HI  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint POS_LO  = -64'sh4000_0000_0000_0000;
  localparam longint VEL_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VEL_LO  = -64'sh0000_8000_0000_0000;
  localparam longint unsigned RMIN_M  = 64'd2084400;
  localparam longint unsigned GM_128  = 64'd6272346956800000000;
  localparam longint MOON_DQ = 64'sd19660800000;

  typedef struct {
    logic        hit;
    logic [9:0]  hit_step;
    logic [46:0] fx;
    logic [46:0] fy;
  } flight_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_launch_vel_x = '0, in_launch_vel_y = '0;
  logic out_valid, out_hit;
  logic [STEP_W-1:0] out_hit_step;
  logic signed [46:0] out_final_x, out_final_y;

  // register shadow
  logic signed [40:0] sh_start_x = 41'sd30000000, sh_start_y = -41'sd20000000;
  logic signed [40:0] sh_tgt_x = 41'sd40000000, sh_tgt_y = 41'sd30000000;
  logic [39:0] sh_radius = 40'd100000;

  flight_t pending_flights[$];
  int errors = 0, launched = 0, landed = 0, hits_seen = 0, burst_left = 0;
  int cycles = 0;

  slingshot_trajectory_hit_test #(.STEPS(NSTEPS)) u_top (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_launch_vel_x(in_launch_vel_x), .in_launch_vel_y(in_launch_vel_y),
    .out_valid(out_valid), .out_hit(out_hit), .out_hit_step(out_hit_step),
    .out_final_x(out_final_x), .out_final_y(out_final_y)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_flights.size());
      $display("** slingshot_trajectory_hit_test: FAILED **");
      $finish;
    end
  end

  function automatic longint unsigned mag64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp64(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned sqrt_floor(input longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // velocity kick towards the moon for one step, Q16 m/s
  function automatic void moon_pull(input longint dx, input longint dy,
                                    output longint gx, output longint gy);
    longint unsigned ax = mag64(dx), ay = mag64(dy);
    longint unsigned mx = ax > ay ? ax : ay;
    longint unsigned ex, ey, rs, rm, dv;
    int s = 0;
    while ((mx >> s) >= 64'd2147483648) s++;
    ex = ax >> s;
    ey = ay >> s;
    gx = 0;
    gy = 0;
    if (ex == 0 && ey == 0) return;
    rs = sqrt_floor(ex * ex + ey * ey);
    rm = s > 16 ? rs << (s - 16) : rs >> (16 - s);
    if (rm < RMIN_M) rm = RMIN_M;
    dv = ((GM_128 / rm) * 512) / rm;
    gx = longint'(dv * ex / rs);
    gy = longint'(dv * ey / rs);
    if (dx < 0) gx = -gx;
    if (dy < 0) gy = -gy;
  endfunction

  function automatic logic in_circle(input longint px, input longint py);
    longint unsigned ax = mag64(px - longint'(sh_tgt_x) * 65536);
    longint unsigned ay = mag64(py - longint'(sh_tgt_y) * 65536);
    logic [127:0] rq = {88'd0, sh_radius} << 16;
    logic [127:0] d2;
    d2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    return d2 <= rq * rq;
  endfunction

  // integrate one trial; with aim off, run nsteps without the target test
  function automatic flight_t fly(input logic signed [15:0] lvx, input logic signed [15:0] lvy,
                                  input int nsteps, input bit aim);
    flight_t f;
    longint vx = longint'(lvx) * 65536, vy = longint'(lvy) * 65536;
    longint px = longint'(sh_start_x) * 65536, py = longint'(sh_start_y) * 65536;
    longint moonx = 0, gx, gy;
    longint fxq, fyq;
    f.hit = 1'b0;
    f.hit_step = '0;
    for (int k = 0; k < nsteps; k++) begin
      moon_pull(moonx - px, -py, gx, gy);
      vx = clamp64(vx + gx, VEL_LO, VEL_HI);
      vy = clamp64(vy + gy, VEL_LO, VEL_HI);
      px = clamp64(px + vx * 200, POS_LO, POS_HI);
      py = clamp64(py + vy * 200, POS_LO, POS_HI);
      moonx += MOON_DQ;
      if (aim && in_circle(px, py)) begin
        f.hit = 1'b1;
        f.hit_step = k[9:0];
        break;
      end
    end
    fxq = px >>> 16;
    fyq = py >>> 16;
    f.fx = fxq[46:0];
    f.fy = fyq[46:0];
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    flight_t w;
    if (rst_n && out_valid) begin
      if (pending_flights.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        w = pending_flights.pop_front();
        landed++;
        if (out_hit) hits_seen++;
        if (out_hit !== w.hit) flag_mismatch("hit", out_hit, w.hit);
        if (out_hit_step !== w.hit_step) flag_mismatch("hit_step", out_hit_step, w.hit_step);
        if (out_final_x !== w.fx) flag_mismatch("final_x", out_final_x, $signed(w.fx));
        if (out_final_y !== w.fy) flag_mismatch("final_y", out_final_y, $signed(w.fy));
      end
    end
  end

  task automatic launch(input logic signed [15:0] vx, input logic signed [15:0] vy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    in_launch_vel_x <= vx;
    in_launch_vel_y <= vy;
    do @(posedge clk); while (busy);
    pending_flights.push_back(fly(vx, vy, NSTEPS, 1'b1));
    launched++;
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_flights.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      REG_START_X:  sh_start_x = value[40:0];
      REG_START_Y:  sh_start_y = value[40:0];
      REG_TARGET_X: sh_tgt_x   = value[40:0];
      REG_TARGET_Y: sh_tgt_y   = value[40:0];
      REG_RADIUS:   sh_radius  = value[39:0];
      default: ;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(input longint sx, input longint sy, input longint tx,
                         input longint ty, input longint unsigned rad);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_RADIUS, rad);
  endtask

  task automatic launch_random(input int n);
    repeat (n) launch($urandom, $urandom);
  endtask

  task automatic test_default_setup();
    launch(16'sd0, 16'sd0);
    launch(16'sh7FFF, 16'sh7FFF);
    launch(-16'sh8000, -16'sh8000);
    launch(16'sh7FFF, -16'sh8000);
    launch(-16'sh8000, 16'sh7FFF);
    launch(16'sd1, -16'sd1);
    drain();
  endtask

  // craft sits on the moon at launch: no pull in the first step
  task automatic test_zero_distance();
    set_all(0, 0, 64'sd1000000000, 64'sd1000000000, 0);
    launch(16'sd0, 16'sd0);
    launch(16'sd1000, -16'sd1000);
    drain();
  endtask

  // far from the moon the pull floors to zero, so exact centre hits are reachable
  task automatic test_exact_centre();
    longint far_x = 64'sd1000000000000;
    set_all(far_x, -far_x, far_x, -far_x, 0);
    launch(16'sd0, 16'sd0);
    drain();
    write_reg(REG_TARGET_X, far_x + 200 * 7);
    launch(16'sd1, 16'sd0);
    launch(16'sd2, 16'sd0);
    drain();
    write_reg(REG_TARGET_X, far_x + 200 * 100);
    launch(16'sd1, 16'sd0);
    drain();
  endtask

  task automatic test_extreme_registers();
    set_all(64'sd1099511627775, -64'sd1099511627776, -64'sd1099511627776,
            64'sd1099511627775, 64'd1099511627775);
    launch(16'sh7FFF, 16'sh7FFF);
    launch(-16'sh8000, 16'sd0);
    drain();
    set_all(-64'sd1099511627776, 64'sd1099511627775, 64'sd1099511627775,
            -64'sd1099511627776, 64'd1099511627775);
    launch(-16'sh8000, -16'sh8000);
    launch(16'sd5, 16'sd5);
    drain();
    set_all(64'sd3000000, 64'sd0, 64'sd0, 64'sd0, 64'd1099511627775);
    launch(16'sd0, 16'sd0);
    drain();
  endtask

  task automatic test_random_setups(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_all($signed(41'($urandom_range(0, 1) ? {$urandom, $urandom} : $urandom_range(0, 50000000))),
              $signed(41'({$urandom, $urandom})), $signed(41'({$urandom, $urandom})),
              $signed(41'({$urandom, $urandom})), 40'({$urandom, $urandom}) >> $urandom_range(0, 39));
      launch_random(per_phase);
      drain();
    end
  endtask

  // aim the target at a point of a nominal trajectory and scatter launches round it
  task automatic test_aimed(input int phases, input int per_phase);
    flight_t f;
    logic signed [15:0] bx, by;
    for (int p = 0; p < phases; p++) begin
      set_all($signed(32'($urandom_range(0, 60000000))) - 64'sd30000000,
              $signed(32'($urandom_range(0, 60000000))) - 64'sd30000000, 0, 0,
              $urandom_range(20000, 3000000));
      bx = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      by = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      f = fly(bx, by, $urandom_range(1, NSTEPS), 1'b0);
      write_reg(REG_TARGET_X, {{17{f.fx[46]}}, f.fx});
      write_reg(REG_TARGET_Y, {{17{f.fy[46]}}, f.fy});
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 5) == 0) launch($urandom, $urandom);
        else launch(bx + $signed(16'($urandom_range(0, 400))) - 16'sd200,
                    by + $signed(16'($urandom_range(0, 400))) - 16'sd200);
      end
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_setup();
    test_zero_distance();
    test_exact_centre();
    test_extreme_registers();
    test_random_setups(6, 80);
    test_aimed(12, 60);
    set_all(64'sd30000000, -64'sd20000000, 64'sd40000000, 64'sd30000000, 100000);
    launch_random(30);
    drain();
    repeat (NSTEPS * RING / 10) @(posedge clk);
    $display("trials launched %0d, results checked %0d, hits %0d", launched, landed, hits_seen);
    $display("covered default, zero-distance, exact-centre, extreme and aimed setups");
    if (errors == 0 && pending_flights.size() == 0) begin
      $display("** slingshot_trajectory_hit_test: PASSED **");
    end else begin
      $display("** slingshot_trajectory_hit_test: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sth_pkg.sv
rtl/sth_div_pipe.sv
rtl/sth_sqrt_pipe.sv
rtl/slingshot_trajectory_hit_test.sv
tb/tb_slingshot_trajectory_hit_test.sv
